[hdl/ptot_pkg.sv]
// Shared types, widths and helper functions for the pulse time-over-threshold block.
// Used by the datapath, divider, controller, top level and checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ptot_pkg;

   localparam int SAMPLE_W  = 14;
   localparam int BASE_W    = 18;
   localparam int OFFSET_W  = 16;
   localparam int RUN_W     = 4;
   localparam int PEAK_W    = 19;
   localparam int AREA_W    = 29;
   localparam int TIME_W    = 18;
   localparam int STATUS_W  = 2;
   localparam int WHOLE_W   = 12;
   localparam int FRAC_W    = 9;
   localparam int OPER_W    = 20;
   localparam int DIV_STEPS = 8;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);
   localparam int CSR_IDX_W = 2;

   localparam logic [RUN_W-1:0]    RUN_MAX  = '1;
   localparam logic [TIME_W-1:0]   TIME_MAX = '1;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_RUN    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNORDERED = 2'd2;

   // Register indexes; each register sits at byte address 4 * index.
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD_OFFSET = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_RUN          = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_CEILING      = 2'd2;

   typedef enum logic [1:0] {
      ST_RUN,
      ST_DIV,
      ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic div_commit;
      logic finish_load;
   } dp_cmd_type;

   typedef struct packed {
      logic div_req;
      logic div_done;
   } dp_status_type;

   // Whole samples plus a 1/256 fraction, saturated to the time field.
   function automatic logic [TIME_W-1:0] make_time(input logic [WHOLE_W-1:0] whole,
                                                   input logic [FRAC_W-1:0]  frac);
      logic [WHOLE_W+8:0] t;
      t = {whole, 8'b0} + (WHOLE_W + 9)'(frac);
      return (t > (WHOLE_W + 9)'(TIME_MAX)) ? TIME_MAX : t[TIME_W-1:0];
   endfunction

endpackage

`default_nettype wire

[hdl/pulse_time_over_threshold.sv]
// A result is offered after the transfer of the window's last sample, and after the shared
// fraction divider's 8 steps and commit when that sample needs an interpolated crossing.
// Throughput: one sample per cycle; the input is held for each interpolated crossing
// and each window close, and a closing sample waits while an earlier result is held.
// Reset (synchronous, active high) clears the controller, the window index and run state,
// and loads the registers with threshold_offset 80, min_run 3 and min_ceiling 1000.
`timescale 1ns / 1ps
`default_nettype none

module pulse_time_over_threshold
   import ptot_pkg::*;
#(
   parameter int MAX_WINDOW = 1024
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // Sample channel.
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [SAMPLE_W-1:0]  req_sample,
   input  wire logic [BASE_W-1:0]    req_baseline,
   input  wire logic                 req_last,
   // Result channel.
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic signed [PEAK_W-1:0]  rsp_peak_height,
   output logic signed [AREA_W-1:0]  rsp_area,
   output logic [TIME_W-1:0]         rsp_fall_time,
   output logic [TIME_W-1:0]         rsp_rise_time,
   output logic [TIME_W-1:0]         rsp_pulse_width,
   output logic [STATUS_W-1:0]       rsp_status,
   // Register port.
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic [3:0]           paddr,
   input  wire logic [31:0]          pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);

   // Register map: one 32-bit word per register, indexes from the package.
   logic [OFFSET_W-1:0]  threshold_offset_ff, threshold_offset_in;
   logic [RUN_W-1:0]     min_run_ff, min_run_in;
   logic [SAMPLE_W-1:0]  min_ceiling_ff, min_ceiling_in;
   logic                 csr_write;
   logic [CSR_IDX_W-1:0] csr_index;

   dp_cmd_type          cmd;
   dp_status_type       status;

   assign pready    = 1'b1;
   assign csr_index = paddr[3:2];
   assign csr_write = psel && penable && pwrite;

   // Registers are written in the access phase of a write transfer.
   always_comb begin
      threshold_offset_in = threshold_offset_ff;
      min_run_in          = min_run_ff;
      min_ceiling_in      = min_ceiling_ff;
      if (csr_write) begin
         case (csr_index)
            REG_THRESHOLD_OFFSET: threshold_offset_in = pwdata[OFFSET_W-1:0];
            REG_MIN_RUN:          min_run_in          = pwdata[RUN_W-1:0];
            REG_MIN_CEILING:      min_ceiling_in      = pwdata[SAMPLE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_THRESHOLD_OFFSET: prdata = {{(32 - OFFSET_W){1'b0}}, threshold_offset_ff};
         REG_MIN_RUN:          prdata = {{(32 - RUN_W){1'b0}}, min_run_ff};
         REG_MIN_CEILING:      prdata = {{(32 - SAMPLE_W){1'b0}}, min_ceiling_ff};
         default:              prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_offset_ff <= OFFSET_W'(80);
         min_run_ff          <= RUN_W'(3);
         min_ceiling_ff      <= SAMPLE_W'(1000);
      end else begin
         threshold_offset_ff <= threshold_offset_in;
         min_run_ff          <= min_run_in;
         min_ceiling_ff      <= min_ceiling_in;
      end
   end

   // The controller owns both handshakes; the datapath does the per-sample work and
   // requests an interpolation whenever a crossing needs its fraction computed.
   ptot_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_last),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ptot_datapath #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .threshold_offset (threshold_offset_ff),
      .min_run          (min_run_ff),
      .min_ceiling      (min_ceiling_ff),
      .sample           (req_sample),
      .baseline         (req_baseline),
      .last             (req_last),
      .peak_height      (rsp_peak_height),
      .area             (rsp_area),
      .fall_time        (rsp_fall_time),
      .rise_time        (rsp_rise_time),
      .pulse_width      (rsp_pulse_width),
      .pulse_status     (rsp_status)
   );

endmodule

`default_nettype wire

[hdl/ptot_div.sv]
// Iterative fraction divider: floor(256 * num / den) clamped to [0, 256], one bit a cycle.
// Depends on ptot_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptot_div
   import ptot_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic signed [OPER_W-1:0] num,
   input  wire logic signed [OPER_W-1:0] den,
   output logic                          done,
   output logic [FRAC_W-1:0]             frac
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [OPER_W-2:0]    rem_ff, rem_in;
   logic [OPER_W-2:0]    den_ff, den_in;
   logic [7:0]           quo_ff, quo_in;
   logic                 full_ff, full_in;
   logic                 zero_ff, zero_in;

   logic [OPER_W-1:0]    rem2;
   logic [OPER_W-1:0]    diff;
   logic                 ge;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      full_in = full_ff;
      zero_in = zero_ff;
      rem2    = {rem_ff, 1'b0};
      diff    = rem2 - {1'b0, den_ff};
      ge      = rem2 >= {1'b0, den_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = '0;
         zero_in = (den <= 0) || (num <= 0);
         full_in = (den > 0) && (num > 0) && (num >= den);
         rem_in  = num[OPER_W-2:0];
         den_in  = den[OPER_W-2:0];
      end else if (busy_ff) begin
         quo_in = {quo_ff[6:0], ge};
         rem_in = ge ? diff[OPER_W-2:0] : rem2[OPER_W-2:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
      full_ff <= full_in;
      zero_ff <= zero_in;
   end

   assign done = done_ff;
   assign frac = full_ff ? FRAC_W'(256) : (zero_ff ? '0 : {1'b0, quo_ff});

endmodule

`default_nettype wire

[hdl/ptot_datapath.sv]
// Per-sample datapath: baseline latch, running minimum, area, run tracking, crossing
// captures and the result register. Depends on ptot_pkg and ptot_div.
`timescale 1ns / 1ps
`default_nettype none

module ptot_datapath
   import ptot_pkg::*;
#(
   parameter int MAX_WINDOW = 1024
)
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire dp_cmd_type                  cmd,
   output dp_status_type                    status,
   input  wire logic [OFFSET_W-1:0]         threshold_offset,
   input  wire logic [RUN_W-1:0]            min_run,
   input  wire logic [SAMPLE_W-1:0]         min_ceiling,
   input  wire logic [SAMPLE_W-1:0]         sample,
   input  wire logic [BASE_W-1:0]           baseline,
   input  wire logic                        last,
   output logic signed [PEAK_W-1:0]         peak_height,
   output logic signed [AREA_W-1:0]         area,
   output logic [TIME_W-1:0]                fall_time,
   output logic [TIME_W-1:0]                rise_time,
   output logic [TIME_W-1:0]                pulse_width,
   output logic [STATUS_W-1:0]              pulse_status
);

   localparam int IDX_W      = $clog2(MAX_WINDOW);
   localparam int AREA_SUM_W = AREA_W + 2;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_WINDOW - 1);
   localparam logic signed [AREA_SUM_W-1:0] AREA_HI = AREA_SUM_W'(268435455);
   localparam logic signed [AREA_SUM_W-1:0] AREA_LO = -AREA_SUM_W'(268435456);
   localparam logic signed [OPER_W-1:0]     PEAK_HI = OPER_W'(262143);
   localparam logic signed [OPER_W-1:0]     PEAK_LO = -OPER_W'(262144);

   // Window state.
   logic [IDX_W-1:0]              idx_ff, idx_in;
   logic [BASE_W-1:0]             baseline_ff, baseline_in;
   logic [SAMPLE_W-1:0]           min_ff, min_in;
   logic signed [AREA_W-1:0]      area_ff, area_in;
   logic [RUN_W-1:0]              run_ff, run_in;
   logic [SAMPLE_W-1:0]           prev_ff, prev_in;
   logic [IDX_W-1:0]              start_idx_ff, start_idx_in;
   logic [SAMPLE_W-1:0]           start_before_ff, start_before_in;
   logic [SAMPLE_W-1:0]           start_first_ff, start_first_in;
   logic                          fall_found_ff, fall_found_in;
   logic [TIME_W-1:0]             fall_time_ff, fall_time_in;
   logic                          rise_found_ff, rise_found_in;
   logic [TIME_W-1:0]             rise_time_ff, rise_time_in;
   logic [IDX_W-1:0]              div_whole_ff, div_whole_in;
   logic                          div_to_rise_ff, div_to_rise_in;

   // Result register.
   logic signed [PEAK_W-1:0]      res_peak_ff, res_peak_in;
   logic signed [AREA_W-1:0]      res_area_ff, res_area_in;
   logic [TIME_W-1:0]             res_fall_ff, res_fall_in;
   logic [TIME_W-1:0]             res_rise_ff, res_rise_in;
   logic [TIME_W-1:0]             res_width_ff, res_width_in;
   logic [STATUS_W-1:0]           res_status_ff, res_status_in;

   // Per-sample terms.
   logic                          first;
   logic [BASE_W-1:0]             base_cur;
   logic [SAMPLE_W-1:0]           min_cur;
   logic signed [AREA_W-1:0]      area_cur;
   logic signed [AREA_SUM_W-1:0]  area_sum;
   logic [BASE_W-1:0]             s16;
   logic signed [OPER_W-1:0]      s16_op;
   logic signed [OPER_W-1:0]      thr;
   logic signed [OPER_W-1:0]      before16_op;
   logic signed [OPER_W-1:0]      first16_op;
   logic signed [OPER_W-1:0]      prev16_op;
   logic                          below;
   logic [RUN_W-1:0]              mr;
   logic [RUN_W-1:0]              run_cur;
   logic [RUN_W-1:0]              run_next;
   logic                          fall_found_cur;
   logic                          rise_found_cur;
   logic [IDX_W-1:0]              st_idx;
   logic [SAMPLE_W-1:0]           st_before;
   logic [SAMPLE_W-1:0]           st_first;
   logic                          fall_event;
   logic                          fall_div;
   logic                          rise_last_event;
   logic                          rise_end_event;
   logic                          rise_div;
   logic [TIME_W-1:0]             idx_time;
   logic signed [OPER_W-1:0]      div_num;
   logic signed [OPER_W-1:0]      div_den;
   logic                          div_done;
   logic [FRAC_W-1:0]             div_frac;
   logic [TIME_W-1:0]             commit_time;
   logic signed [OPER_W-1:0]      peak_full;
   logic                          both_found;

   always_comb begin
      first          = (idx_ff == '0);
      base_cur       = first ? baseline : baseline_ff;
      min_cur        = first ? min_ceiling : min_ff;
      area_cur       = first ? '0 : area_ff;
      run_cur        = first ? '0 : run_ff;
      fall_found_cur = first ? 1'b0 : fall_found_ff;
      rise_found_cur = first ? 1'b0 : rise_found_ff;

      s16      = {sample, 4'b0};
      area_sum = AREA_SUM_W'(area_cur)
               + $signed({{(AREA_SUM_W - BASE_W){1'b0}}, base_cur})
               - $signed({{(AREA_SUM_W - BASE_W){1'b0}}, s16});

      s16_op = $signed({{(OPER_W - BASE_W){1'b0}}, s16});
      thr    = $signed({{(OPER_W - BASE_W){1'b0}}, base_cur})
             - $signed({{(OPER_W - OFFSET_W){1'b0}}, threshold_offset});
      below  = s16_op < thr;

      mr       = (min_run == '0) ? RUN_W'(1) : min_run;
      run_next = (run_cur == RUN_MAX) ? RUN_MAX : run_cur + 1'b1;

      // A new run takes its start from the current sample and the sample before it.
      st_idx    = (run_cur == '0) ? idx_ff  : start_idx_ff;
      st_before = (run_cur == '0) ? prev_ff : start_before_ff;
      st_first  = (run_cur == '0) ? sample  : start_first_ff;

      before16_op = $signed({{(OPER_W - BASE_W){1'b0}}, st_before, 4'b0});
      first16_op  = $signed({{(OPER_W - BASE_W){1'b0}}, st_first, 4'b0});
      prev16_op   = $signed({{(OPER_W - BASE_W){1'b0}}, prev_ff, 4'b0});

      idx_time = make_time(WHOLE_W'(idx_ff), '0);

      fall_event      = below && (run_next >= mr) && !fall_found_cur;
      fall_div        = fall_event && (st_idx != '0) && !(last && (st_idx == idx_ff));
      rise_last_event = below && last && (run_next >= mr);
      rise_end_event  = !below && (run_cur >= mr) && (idx_ff != '0);
      rise_div        = rise_end_event && (idx_ff != IDX_W'(1));

      if (rise_div) begin
         div_num = thr - prev16_op;
         div_den = s16_op - prev16_op;
      end else begin
         div_num = before16_op - thr;
         div_den = before16_op - first16_op;
      end

      status.div_req  = fall_div || rise_div;
      status.div_done = div_done;
   end

   ptot_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.accept && status.div_req),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .frac  (div_frac)
   );

   always_comb begin
      idx_in          = idx_ff;
      baseline_in     = baseline_ff;
      min_in          = min_ff;
      area_in         = area_ff;
      run_in          = run_ff;
      prev_in         = prev_ff;
      start_idx_in    = start_idx_ff;
      start_before_in = start_before_ff;
      start_first_in  = start_first_ff;
      fall_found_in   = fall_found_ff;
      fall_time_in    = fall_time_ff;
      rise_found_in   = rise_found_ff;
      rise_time_in    = rise_time_ff;
      div_whole_in    = div_whole_ff;
      div_to_rise_in  = div_to_rise_ff;
      commit_time     = make_time(WHOLE_W'(div_whole_ff), div_frac);

      if (cmd.accept) begin
         if (last) begin
            idx_in = '0;
         end else if (idx_ff != IDX_LAST) begin
            idx_in = idx_ff + 1'b1;
         end
         baseline_in = base_cur;
         min_in      = (sample < min_cur) ? sample : min_cur;
         if (area_sum > AREA_HI) begin
            area_in = AREA_HI[AREA_W-1:0];
         end else if (area_sum < AREA_LO) begin
            area_in = AREA_LO[AREA_W-1:0];
         end else begin
            area_in = area_sum[AREA_W-1:0];
         end
         run_in  = below ? run_next : '0;
         prev_in = sample;
         if (below && (run_cur == '0)) begin
            start_idx_in    = idx_ff;
            start_before_in = prev_ff;
            start_first_in  = sample;
         end

         fall_found_in = fall_found_cur || fall_event;
         if (fall_event && !fall_div) begin
            fall_time_in = (st_idx == '0) ? '0 : idx_time;
         end

         rise_found_in = rise_found_cur || rise_last_event || rise_end_event;
         if (rise_last_event) begin
            rise_time_in = idx_time;
         end else if (rise_end_event && !rise_div) begin
            rise_time_in = '0;
         end

         if (status.div_req) begin
            div_to_rise_in = rise_div;
            div_whole_in   = rise_div ? idx_ff - 1'b1 : st_idx - 1'b1;
         end
      end

      if (cmd.div_commit) begin
         if (div_to_rise_ff) begin
            rise_time_in = commit_time;
         end else begin
            fall_time_in = commit_time;
         end
      end
   end

   // Result of a closed window, built from the settled window state.
   always_comb begin
      res_peak_in   = res_peak_ff;
      res_area_in   = res_area_ff;
      res_fall_in   = res_fall_ff;
      res_rise_in   = res_rise_ff;
      res_width_in  = res_width_ff;
      res_status_in = res_status_ff;
      peak_full     = $signed({{(OPER_W - BASE_W){1'b0}}, baseline_ff})
                    - $signed({{(OPER_W - BASE_W){1'b0}}, min_ff, 4'b0});
      both_found    = fall_found_ff && rise_found_ff;

      if (cmd.finish_load) begin
         if (peak_full > PEAK_HI) begin
            res_peak_in = PEAK_HI[PEAK_W-1:0];
         end else if (peak_full < PEAK_LO) begin
            res_peak_in = PEAK_LO[PEAK_W-1:0];
         end else begin
            res_peak_in = peak_full[PEAK_W-1:0];
         end
         res_area_in = area_ff;
         if (!both_found) begin
            res_fall_in   = '0;
            res_rise_in   = '0;
            res_width_in  = '0;
            res_status_in = STATUS_NO_RUN;
         end else begin
            res_fall_in = fall_time_ff;
            res_rise_in = rise_time_ff;
            if (fall_time_ff < rise_time_ff) begin
               res_width_in  = rise_time_ff - fall_time_ff;
               res_status_in = STATUS_OK;
            end else begin
               res_width_in  = '0;
               res_status_in = STATUS_UNORDERED;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         run_ff        <= '0;
         fall_found_ff <= 1'b0;
         rise_found_ff <= 1'b0;
         baseline_ff   <= '0;
         min_ff        <= SAMPLE_W'(1000);
         area_ff       <= '0;
         prev_ff       <= '0;
      end else begin
         idx_ff        <= idx_in;
         run_ff        <= run_in;
         fall_found_ff <= fall_found_in;
         rise_found_ff <= rise_found_in;
         baseline_ff   <= baseline_in;
         min_ff        <= min_in;
         area_ff       <= area_in;
         prev_ff       <= prev_in;
      end
      start_idx_ff    <= start_idx_in;
      start_before_ff <= start_before_in;
      start_first_ff  <= start_first_in;
      fall_time_ff    <= fall_time_in;
      rise_time_ff    <= rise_time_in;
      div_whole_ff    <= div_whole_in;
      div_to_rise_ff  <= div_to_rise_in;
      res_peak_ff     <= res_peak_in;
      res_area_ff     <= res_area_in;
      res_fall_ff     <= res_fall_in;
      res_rise_ff     <= res_rise_in;
      res_width_ff    <= res_width_in;
      res_status_ff   <= res_status_in;
   end

   assign peak_height  = res_peak_ff;
   assign area         = res_area_ff;
   assign fall_time    = res_fall_ff;
   assign rise_time    = res_rise_ff;
   assign pulse_width  = res_width_ff;
   assign pulse_status = res_status_ff;

endmodule

`default_nettype wire

[hdl/ptot_ctrl.sv]
// Controller: input stall, interpolation wait, window close and result valid.
// Depends on ptot_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptot_ctrl
   import ptot_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic          req_last,
   output logic               req_stall,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   ctrl_state_type state_ff, state_in;
   logic           last_pending_ff, last_pending_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in        = state_ff;
      last_pending_in = last_pending_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      cmd             = '0;
      req_stall       = 1'b1;

      case (state_ff)
         ST_RUN: begin
            // A closing sample waits while an earlier result is still held.
            req_stall  = req_last && rsp_valid_ff && rsp_stall;
            cmd.accept = req_valid && !req_stall;
            if (cmd.accept) begin
               last_pending_in = req_last;
               if (status.div_req) begin
                  state_in = ST_DIV;
               end else if (req_last) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_DIV: begin
            if (status.div_done) begin
               cmd.div_commit = 1'b1;
               state_in       = last_pending_ff ? ST_FINISH : ST_RUN;
            end
         end
         ST_FINISH: begin
            cmd.finish_load = 1'b1;
            rsp_valid_in    = 1'b1;
            state_in        = ST_RUN;
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_RUN;
         last_pending_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         last_pending_ff <= last_pending_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

[hdl/ptot_checker.sv]
// Port-level checker for the pulse time-over-threshold block, with its bind statement.
// Depends on ptot_pkg and the top level's port list.
`timescale 1ns / 1ps
`default_nettype none

module ptot_checker
   import ptot_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_stall,
   input wire logic [TIME_W-1:0]    rsp_fall_time,
   input wire logic [TIME_W-1:0]    rsp_rise_time,
   input wire logic [TIME_W-1:0]    rsp_pulse_width,
   input wire logic [STATUS_W-1:0]  rsp_status
);

   // A held result stays offered until its transfer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK) || (rsp_status == STATUS_NO_RUN)
                    || (rsp_status == STATUS_UNORDERED))
      else $error("undefined status code");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |-> rsp_pulse_width == '0)
      else $error("width reported without a valid pulse");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_NO_RUN)
         |-> (rsp_fall_time == '0) && (rsp_rise_time == '0))
      else $error("times reported without a qualifying run");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_OK)
         |-> (rsp_rise_time > rsp_fall_time)
             && (TIME_W'(rsp_rise_time - rsp_fall_time) == rsp_pulse_width))
      else $error("pulse width does not match crossing times");

endmodule

bind pulse_time_over_threshold ptot_checker u_ptot_checker (.*);

`default_nettype wire
